[sv/keypad_four_function_calculator_defines.svh]
// Assertion helpers for the keypad calculator.
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_DEFINES_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define KPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/kpc_pkg.sv]
package kpc_pkg;

	// output field widths
	localparam int VALUE_W  = 20;
	localparam int DIGITS_W = 3;
	localparam int RES_W    = 41;
	localparam int HUND_W   = 7;

	localparam int DEF_MAX_DIGITS = 6;

	// key codes
	localparam logic [7:0] KEY_0    = 8'h30;
	localparam logic [7:0] KEY_9    = 8'h39;
	localparam logic [7:0] KEY_A    = 8'h41;
	localparam logic [7:0] KEY_B    = 8'h42;
	localparam logic [7:0] KEY_C    = 8'h43;
	localparam logic [7:0] KEY_D    = 8'h44;
	localparam logic [7:0] KEY_STAR = 8'h2A;
	localparam logic [7:0] KEY_HASH = 8'h23;

	localparam int TEN     = 10;
	localparam int HUNDRED = 100;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_OP     = 2'd1,
		PH_SECOND = 2'd2,
		PH_RESULT = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OP_DIV = 2'd0,
		OP_MUL = 2'd1,
		OP_SUB = 2'd2,
		OP_ADD = 2'd3
	} op_t;

	// bits needed for the largest n-digit decimal value
	function automatic int val_width(input int n);
		longint p;
		int w;
		p = 1;
		w = 0;
		for (int i = 0; i < n; i++) p = p * 10;
		p = p - 1;
		while (p > 0) begin
			w++;
			p = p >>> 1;
		end
		return w;
	endfunction

endpackage

[sv/keypad_four_function_calculator.sv]
// Channel   Dir  Handshake            Payload
// key       in   key_valid/key_stall  key_code
// result    out  res_valid/res_stall  phase, operation, entry_value, entry_digits,
//                                     result_valid, divide_by_zero,
//                                     result_integer, result_hundredths
//
// Work per key (default MAX_DIGITS = 6, VAL_W = 20, N_W = VAL_W + 7 = 27):
//   digit, confirm, operation, add, subtract, ignored key: done at once, then published
//   delete: one quotient bit per cycle through the divider
//   multiply: one shift-add step per cycle
//   divide: divider run twice (by second number, then by 100)
// Reset clears the phase, operation, both numbers and the output register.
// A key is taken only while the sequencer is idle; the result register may
// still hold an untaken beat then, and a new beat waits behind it.
module keypad_four_function_calculator #(
	parameter int MAX_DIGITS = kpc_pkg::DEF_MAX_DIGITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                key_valid,
	output logic                                key_stall,
	input  logic [7:0]                          key_code,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [1:0]                          phase,
	output logic [1:0]                          operation,
	output logic [kpc_pkg::VALUE_W-1:0]         entry_value,
	output logic [kpc_pkg::DIGITS_W-1:0]        entry_digits,
	output logic                                result_valid,
	output logic                                divide_by_zero,
	output logic signed [kpc_pkg::RES_W-1:0]    result_integer,
	output logic [kpc_pkg::HUND_W-1:0]          result_hundredths
);
	import kpc_pkg::*;

	`include "keypad_four_function_calculator_defines.svh"

	// number storage width, dividend width (value * 100), divisor width
	localparam int VAL_W = val_width(MAX_DIGITS);
	localparam int N_W   = VAL_W + 7;
	localparam int DV_W  = (VAL_W > 7) ? VAL_W : 7;
	localparam int IT_W  = $clog2(N_W);
	localparam int DG_W  = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEL,
		ST_DIV1,
		ST_DIV2,
		ST_MUL,
		ST_PUB
	} state_t;

	state_t state_q;
	phase_t phase_q;
	op_t    op_q;

	logic [VAL_W-1:0] first_q, second_q;
	logic [DG_W-1:0]  first_dg_q, second_dg_q;

	// shared restoring divider: dividend shifts out, quotient shifts in
	logic [N_W-1:0]  dq_q;
	logic [DV_W-1:0] rem_q;
	logic [DV_W-1:0] dv_q;
	logic [IT_W-1:0] it_q;

	// shift-add multiplier
	logic [VAL_W-1:0] mhi_q, mlo_q;

	// computed result
	logic [RES_W-1:0]  res_int_q;
	logic [HUND_W-1:0] res_hund_q;
	logic              dz_q;

	// output beat register
	logic                res_valid_q;
	logic [1:0]          phase_o_q, op_o_q;
	logic [VALUE_W-1:0]  entry_val_o_q;
	logic [DIGITS_W-1:0] entry_dg_o_q;
	logic                rvalid_o_q, dz_o_q;
	logic [RES_W-1:0]    res_int_o_q;
	logic [HUND_W-1:0]   res_hund_o_q;

	logic key_take;
	logic is_digit;
	logic [VAL_W-1:0] cur_val, app_val;
	logic [DG_W-1:0]  cur_dg;
	logic             can_app, can_del;
	logic [N_W-1:0]   f100;

	logic [DV_W:0]    div_sh;
	logic             div_ge;
	logic [DV_W-1:0]  rem_next;
	logic [N_W-1:0]   dq_next;

	logic [VAL_W:0]   mul_sum;
	logic [VAL_W-1:0] mhi_next, mlo_next;

	logic out_free;

	assign key_stall = (state_q != ST_IDLE);
	assign key_take  = key_valid && !key_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// key decode against the number being edited
	assign is_digit = (key_code >= KEY_0) && (key_code <= KEY_9);
	assign cur_val  = (phase_q == PH_FIRST) ? first_q : second_q;
	assign cur_dg   = (phase_q == PH_FIRST) ? first_dg_q : second_dg_q;
	assign can_app  = is_digit && (cur_dg < DG_W'(MAX_DIGITS));
	assign can_del  = (key_code == KEY_HASH) && (cur_dg != '0);
	// v * 10 + d as (v << 3) + (v << 1) + d
	assign app_val  = VAL_W'({cur_val, 3'b000}) + VAL_W'({cur_val, 1'b0})
		+ VAL_W'(key_code[3:0]);
	// first * 100 as (f << 6) + (f << 5) + (f << 2)
	assign f100     = N_W'({first_q, 6'b0}) + N_W'({first_q, 5'b0})
		+ N_W'({first_q, 2'b0});

	// one restoring step
	assign div_sh   = {rem_q, dq_q[N_W-1]};
	assign div_ge   = div_sh >= {1'b0, dv_q};
	assign rem_next = div_ge ? DV_W'(div_sh - {1'b0, dv_q}) : DV_W'(div_sh);
	assign dq_next  = {dq_q[N_W-2:0], div_ge};

	// one shift-add step
	assign mul_sum  = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, first_q} : '0);
	assign mhi_next = mul_sum[VAL_W:1];
	assign mlo_next = {mul_sum[0], mlo_q[VAL_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_FIRST;
			op_q          <= OP_ADD;
			first_q       <= '0;
			second_q      <= '0;
			first_dg_q    <= '0;
			second_dg_q   <= '0;
			dq_q          <= '0;
			rem_q         <= '0;
			dv_q          <= '0;
			it_q          <= '0;
			mhi_q         <= '0;
			mlo_q         <= '0;
			res_int_q     <= '0;
			res_hund_q    <= '0;
			dz_q          <= 1'b0;
			res_valid_q   <= 1'b0;
			phase_o_q     <= '0;
			op_o_q        <= '0;
			entry_val_o_q <= '0;
			entry_dg_o_q  <= '0;
			rvalid_o_q    <= 1'b0;
			dz_o_q        <= 1'b0;
			res_int_o_q   <= '0;
			res_hund_o_q  <= '0;
		end else begin
			// beat taken; a publish in the same cycle reloads it below
			if (res_valid_q && !res_stall && (state_q != ST_PUB)) res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (key_take) begin
						unique case (phase_q)
							PH_FIRST, PH_SECOND: begin
								if (key_code == KEY_STAR) begin
									if (phase_q == PH_FIRST) begin
										phase_q <= PH_OP;
										state_q <= ST_PUB;
									end else begin
										phase_q    <= PH_RESULT;
										dz_q       <= 1'b0;
										res_hund_q <= '0;
										unique case (op_q)
											OP_ADD: begin
												res_int_q <= RES_W'(first_q) + RES_W'(second_q);
												state_q   <= ST_PUB;
											end
											OP_SUB: begin
												res_int_q <= RES_W'(first_q) - RES_W'(second_q);
												state_q   <= ST_PUB;
											end
											OP_MUL: begin
												mhi_q   <= '0;
												mlo_q   <= second_q;
												it_q    <= IT_W'(VAL_W - 1);
												state_q <= ST_MUL;
											end
											OP_DIV: begin
												if (second_q == '0) begin
													dz_q      <= 1'b1;
													res_int_q <= '0;
													state_q   <= ST_PUB;
												end else begin
													dq_q    <= f100;
													rem_q   <= '0;
													dv_q    <= DV_W'(second_q);
													it_q    <= IT_W'(N_W - 1);
													state_q <= ST_DIV1;
												end
											end
											default: state_q <= ST_PUB;
										endcase
									end
								end else if (can_app) begin
									state_q <= ST_PUB;
									if (phase_q == PH_FIRST) begin
										first_q    <= app_val;
										first_dg_q <= first_dg_q + 1'b1;
									end else begin
										second_q    <= app_val;
										second_dg_q <= second_dg_q + 1'b1;
									end
								end else if (can_del) begin
									// divide by ten on the shared divider
									dq_q    <= N_W'(cur_val);
									rem_q   <= '0;
									dv_q    <= DV_W'(TEN);
									it_q    <= IT_W'(N_W - 1);
									state_q <= ST_DEL;
								end else begin
									state_q <= ST_PUB;
								end
							end
							PH_OP: begin
								state_q <= ST_PUB;
								unique case (key_code)
									KEY_A:    op_q <= OP_DIV;
									KEY_B:    op_q <= OP_MUL;
									KEY_C:    op_q <= OP_SUB;
									KEY_D:    op_q <= OP_ADD;
									KEY_STAR: phase_q <= PH_SECOND;
									default:  ;
								endcase
							end
							PH_RESULT: begin
								state_q <= ST_PUB;
								if (key_code == KEY_STAR) begin
									phase_q     <= PH_FIRST;
									first_q     <= '0;
									second_q    <= '0;
									first_dg_q  <= '0;
									second_dg_q <= '0;
								end
							end
							default: state_q <= ST_PUB;
						endcase
					end
				end
				ST_DEL: begin
					dq_q  <= dq_next;
					rem_q <= rem_next;
					it_q  <= it_q - 1'b1;
					if (it_q == '0) begin
						state_q <= ST_PUB;
						if (phase_q == PH_FIRST) begin
							first_q    <= VAL_W'(dq_next);
							first_dg_q <= first_dg_q - 1'b1;
						end else begin
							second_q    <= VAL_W'(dq_next);
							second_dg_q <= second_dg_q - 1'b1;
						end
					end
				end
				ST_DIV1: begin
					dq_q <= dq_next;
					if (it_q == '0) begin
						// quotient goes round again, split by 100
						rem_q   <= '0;
						dv_q    <= DV_W'(HUNDRED);
						it_q    <= IT_W'(N_W - 1);
						state_q <= ST_DIV2;
					end else begin
						rem_q <= rem_next;
						it_q  <= it_q - 1'b1;
					end
				end
				ST_DIV2: begin
					dq_q  <= dq_next;
					rem_q <= rem_next;
					it_q  <= it_q - 1'b1;
					if (it_q == '0) begin
						res_int_q  <= RES_W'(dq_next);
						res_hund_q <= HUND_W'(rem_next);
						state_q    <= ST_PUB;
					end
				end
				ST_MUL: begin
					mhi_q <= mhi_next;
					mlo_q <= mlo_next;
					it_q  <= it_q - 1'b1;
					if (it_q == '0) begin
						res_int_q <= RES_W'({mhi_next, mlo_next});
						state_q   <= ST_PUB;
					end
				end
				ST_PUB: begin
					if (out_free) begin
						res_valid_q   <= 1'b1;
						phase_o_q     <= phase_q;
						op_o_q        <= op_q;
						entry_val_o_q <= VALUE_W'(cur_val);
						entry_dg_o_q  <= DIGITS_W'(cur_dg);
						rvalid_o_q    <= (phase_q == PH_RESULT) && !dz_q;
						dz_o_q        <= (phase_q == PH_RESULT) && dz_q;
						res_int_o_q   <= (phase_q == PH_RESULT) ? res_int_q : '0;
						res_hund_o_q  <= (phase_q == PH_RESULT) ? res_hund_q : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid         = res_valid_q;
	assign phase             = phase_o_q;
	assign operation         = op_o_q;
	assign entry_value       = entry_val_o_q;
	assign entry_digits      = entry_dg_o_q;
	assign result_valid      = rvalid_o_q;
	assign divide_by_zero    = dz_o_q;
	assign result_integer    = res_int_o_q;
	assign result_hundredths = res_hund_o_q;

	`KPC_ASSERT_NEXT(a_take_leaves_idle, key_take, state_q != ST_IDLE,
		"accepted key did not start work")
	`KPC_ASSERT_NOW(a_digits_bounded,
		1'b1, (first_dg_q <= DG_W'(MAX_DIGITS)) && (second_dg_q <= DG_W'(MAX_DIGITS)),
		"digit count past limit")
	`KPC_ASSERT_NOW(a_mul_context, state_q == ST_MUL,
		(phase_q == PH_RESULT) && (op_q == OP_MUL), "multiply outside result phase")
	`KPC_ASSERT_NOW(a_rvalid_phase, result_valid, phase == PH_RESULT,
		"result flagged outside result phase")
	`KPC_ASSERT_NOW(a_dz_div, divide_by_zero,
		(operation == OP_DIV) && !result_valid, "divide by zero flag inconsistent")

endmodule

[test/tb.sv]
module tb;
	import kpc_pkg::*;

	// what the block shows after one key: one result beat
	typedef struct packed {
		logic [1:0]          phase;
		logic [1:0]          op;
		logic [VALUE_W-1:0]  value;
		logic [DIGITS_W-1:0] digits;
		logic                rv;
		logic                dz;
		logic [RES_W-1:0]    res;
		logic [HUND_W-1:0]   hund;
	} display_t;

	// idle/stall percentages per run phase: none, sender, receiver, both
	localparam int SRC_IDLE[4]  = '{0, 57, 0, 38};
	localparam int RCV_STALL[4] = '{0, 0, 57, 38};
	localparam int KEYS_PER_PHASE = 390;

	logic                      clk;
	logic                      arst_n;
	logic                      key_valid = 1'b0;
	logic                      key_stall;
	logic [7:0]                key_code = 8'd0;
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	logic [1:0]                phase;
	logic [1:0]                operation;
	logic [VALUE_W-1:0]        entry_value;
	logic [DIGITS_W-1:0]       entry_digits;
	logic                      result_valid;
	logic                      divide_by_zero;
	logic signed [RES_W-1:0]   result_integer;
	logic [HUND_W-1:0]         result_hundredths;

	logic [7:0] keys_pending[$];     // keys waiting for the driver
	display_t   expected_display[$]; // predicted beats, oldest first
	int         keys_queued = 0;     // keys that the calculator acts on
	int         src_idle_pct = 0;
	int         rcv_stall_pct = 0;
	int         errors = 0;

	// calculator state as the testbench sees it
	phase_t           calc_phase = PH_FIRST;
	op_t              calc_op = OP_ADD;
	logic [VALUE_W-1:0]  first_num = '0;
	logic [DIGITS_W-1:0] first_cnt = '0;
	logic [VALUE_W-1:0]  second_num = '0;
	logic [DIGITS_W-1:0] second_cnt = '0;

	keypad_four_function_calculator i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.key_valid         (key_valid),
		.key_stall         (key_stall),
		.key_code          (key_code),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.phase             (phase),
		.operation         (operation),
		.entry_value       (entry_value),
		.entry_digits      (entry_digits),
		.result_valid      (result_valid),
		.divide_by_zero    (divide_by_zero),
		.result_integer    (result_integer),
		.result_hundredths (result_hundredths)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// digit entry: append while short of six digits, '#' drops the last digit
	function automatic void edit_entry(input logic [7:0] k, inout logic [VALUE_W-1:0] v,
			inout logic [DIGITS_W-1:0] n);
		if (k >= KEY_0 && k <= KEY_9) begin
			if (n < DEF_MAX_DIGITS) begin
				v = VALUE_W'(v * TEN + (k - KEY_0));
				n = n + 1'b1;
			end
		end else if (k == KEY_HASH) begin
			if (n != 0) begin
				v = VALUE_W'(v / TEN);
				n = n - 1'b1;
			end
		end
	endfunction

	// advance the calculator by one key and queue what it should show
	function automatic void apply_key(input logic [7:0] k);
		display_t    d;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] r;
		logic [63:0] q;
		d = '0;
		r = '0;
		case (calc_phase)
			PH_FIRST: begin
				if (k == KEY_STAR) calc_phase = PH_OP;
				else edit_entry(k, first_num, first_cnt);
			end
			PH_OP: begin
				if (k == KEY_A) calc_op = OP_DIV;
				else if (k == KEY_B) calc_op = OP_MUL;
				else if (k == KEY_C) calc_op = OP_SUB;
				else if (k == KEY_D) calc_op = OP_ADD;
				else if (k == KEY_STAR) calc_phase = PH_SECOND;
			end
			PH_SECOND: begin
				if (k == KEY_STAR) calc_phase = PH_RESULT;
				else edit_entry(k, second_num, second_cnt);
			end
			default: begin
				// clear both numbers, keep the operation
				if (k == KEY_STAR) begin
					calc_phase = PH_FIRST;
					first_num = '0;
					first_cnt = '0;
					second_num = '0;
					second_cnt = '0;
				end
			end
		endcase
		if (calc_phase == PH_RESULT) begin
			a = 64'(first_num);
			b = 64'(second_num);
			d.rv = 1'b1;
			case (calc_op)
				OP_ADD: r = a + b;
				OP_SUB: r = a - b;    // wraps; low 41 bits are the signed difference
				OP_MUL: r = a * b;
				default: begin
					if (b == 0) begin
						d.dz = 1'b1;
						d.rv = 1'b0;
					end else begin
						q = (a * HUNDRED) / b;
						r = q / HUNDRED;
						d.hund = HUND_W'(q % HUNDRED);
					end
				end
			endcase
		end
		d.phase = calc_phase;
		d.op = calc_op;
		d.value = (calc_phase == PH_FIRST) ? first_num : second_num;
		d.digits = (calc_phase == PH_FIRST) ? first_cnt : second_cnt;
		d.res = r[RES_W-1:0];
		expected_display.push_back(d);
	endfunction

	// stimulus helpers: a key the calculator acts on, and one it ignores
	task automatic queue_key(input logic [7:0] k);
		keys_pending.push_back(k);
		keys_queued++;
	endtask

	task automatic queue_stray(input logic [7:0] k);
		keys_pending.push_back(k);
	endtask

	// one number: random length (past six at times), stray deletes, some noise
	task automatic queue_number(input bit zero_bias);
		int   ndig;
		bit   nines;
		bit   zeros;
		ndig = $urandom_range(0, 8);
		nines = ($urandom_range(5) == 0);
		zeros = zero_bias && ($urandom_range(4) == 0);
		for (int i = 0; i < ndig; i++) begin
			if ($urandom_range(9) == 0) queue_key(KEY_HASH);
			if ($urandom_range(19) == 0) queue_stray(8'($urandom_range(255)));
			if (nines) queue_key(KEY_9);
			else if (zeros) queue_key(KEY_0);
			else queue_key(8'(KEY_0 + $urandom_range(9)));
		end
		if ($urandom_range(7) == 0) queue_key(KEY_HASH);
	endtask

	// a whole calculation: first number, operation, second number, result, clear
	task automatic queue_calculation();
		queue_number(1'b0);
		queue_key(KEY_STAR);
		repeat ($urandom_range(0, 3)) queue_key(8'(KEY_A + $urandom_range(3)));
		// digits and deletes mean nothing while the operation is chosen
		if ($urandom_range(5) == 0) queue_stray(($urandom_range(1)) ? KEY_HASH : KEY_0);
		queue_key(KEY_STAR);
		queue_number(1'b1);
		queue_key(KEY_STAR);
		// the result stays up for anything but a confirm
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(3))
				0: queue_stray(8'(KEY_0 + $urandom_range(9)));
				1: queue_stray(8'(KEY_A + $urandom_range(3)));
				2: queue_stray(KEY_HASH);
				default: queue_stray(8'($urandom_range(255)));
			endcase
		end
		queue_key(KEY_STAR);
	endtask

	// driver: a beat moves when valid is high and stall low; predict on that edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid <= 1'b0;
			key_code <= 8'd0;
		end else if (!key_valid || !key_stall) begin
			if (key_valid) apply_key(key_code);
			if (keys_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				key_code <= keys_pending.pop_front();
				key_valid <= 1'b1;
			end else begin
				key_valid <= 1'b0;
			end
		end
	end

	// receiver stall, drawn fresh each cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// monitor: each result beat against the oldest prediction
	always @(posedge clk) begin
		display_t got;
		display_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = {phase, operation, entry_value, entry_digits, result_valid,
				divide_by_zero, result_integer, result_hundredths};
			if (expected_display.size() == 0) begin
				errors++;
				$display("%0t: beat with nothing expected: ph %0d op %0d val %0d dig %0d",
					$time, got.phase, got.op, got.value, got.digits);
			end else begin
				want = expected_display.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch", $time);
					$display("expected ph %0d op %0d val %0d dig %0d rv %0b dz %0b",
						want.phase, want.op, want.value, want.digits, want.rv, want.dz);
					$display("expected res %0d hund %0d", $signed(want.res), want.hund);
					$display("actual   ph %0d op %0d val %0d dig %0d rv %0b dz %0b",
						got.phase, got.op, got.value, got.digits, got.rv, got.dz);
					$display("actual   res %0d hund %0d", $signed(got.res), got.hund);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// delete on an empty entry, then a code the keypad does not have
		queue_key(KEY_HASH);
		queue_stray(8'hFF);
		// seven nines: the seventh is dropped at full length
		repeat (7) queue_key(KEY_9);
		queue_key(KEY_STAR);
		// walk through every operation, ending on multiply
		queue_key(KEY_A);
		queue_key(KEY_C);
		queue_key(KEY_D);
		queue_key(KEY_B);
		queue_key(KEY_STAR);
		// largest product, then clear
		repeat (6) queue_key(KEY_9);
		queue_key(KEY_STAR);
		queue_key(KEY_STAR);
		// divide by an empty second number
		queue_key(8'(KEY_0 + 7));
		queue_key(KEY_STAR);
		queue_key(KEY_A);
		queue_key(KEY_STAR);
		queue_key(KEY_STAR);
		queue_key(KEY_STAR);

		// random calculations under each idling pattern
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = SRC_IDLE[p];
			rcv_stall_pct = RCV_STALL[p];
			while (keys_queued < (p + 1) * KEYS_PER_PHASE) queue_calculation();
			while (keys_pending.size() != 0) @(posedge clk);
		end

		while (key_valid || expected_display.size() != 0) @(posedge clk);
		// the slowest key is divide
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("keypad_four_function_calculator verification clean");
		end else begin
			$display("keypad_four_function_calculator verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("keypad_four_function_calculator verification failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/kpc_pkg.sv
sv/keypad_four_function_calculator.sv
test/tb.sv
